// ===== design/spes_pkg.sv =====
// Shared types and constants for the steepest-edge price selector.
package spes_pkg;

	localparam int DATA_W  = 32;
	localparam int SQ_W    = 2 * DATA_W;
	localparam int PRICE_W = 48;
	localparam int CNT_W   = $clog2(PRICE_W);
	localparam int HEAD_W  = SQ_W - PRICE_W;
	localparam int PORT_IDX_W = 16;

	localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};
	localparam logic [DATA_W-1:0]  TOL_RESET = DATA_W'(1);

	typedef struct packed {
		logic              cand;
		logic              last;
		logic [SQ_W-1:0]   sq;
		logic [DATA_W-1:0] div;
	} spes_item_t;

endpackage

// ===== design/spes_fifo.sv =====
// Small register queue between the classifying front and the dividing back.
module spes_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== design/spes_front.sv =====
// Front part: takes input items, classifies candidates and squares the violation.
module spes_front #(
	parameter int IDX_W = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [spes_pkg::DATA_W-1:0]         cfg_wr_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [79:0]                         s_axis_tdata,
	input  logic                                s_axis_tlast,
	output logic                                push,
	output spes_pkg::spes_item_t                push_item,
	output logic [IDX_W-1:0]                    push_idx,
	input  logic                                queue_full
);

	logic [spes_pkg::DATA_W-1:0] tol_q;
	logic [spes_pkg::DATA_W-1:0] violation;
	logic [spes_pkg::DATA_W-1:0] weight;
	logic [spes_pkg::DATA_W-1:0] mag;
	logic                        take;

	logic                        valid_s1;
	logic                        cand_s1;
	logic                        last_s1;
	logic [spes_pkg::DATA_W-1:0] mag_s1;
	logic [spes_pkg::DATA_W-1:0] div_s1;
	logic [IDX_W-1:0]            idx_s1;

	assign violation     = s_axis_tdata[31:0];
	assign weight        = s_axis_tdata[63:32];
	assign mag           = -violation;
	assign push          = valid_s1 && !queue_full;
	assign s_axis_tready = !valid_s1 || !queue_full;
	assign take          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= spes_pkg::TOL_RESET;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tol_q <= cfg_wr_data;
			end
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cand_s1 <= violation[spes_pkg::DATA_W-1] && (mag > tol_q);
			last_s1 <= s_axis_tlast;
			mag_s1  <= mag;
			div_s1  <= (weight < tol_q) ? tol_q : weight;
			idx_s1  <= s_axis_tdata[64 +: IDX_W];
		end
	end

	always_comb begin
		push_item.cand = cand_s1;
		push_item.last = last_s1;
		push_item.sq   = spes_pkg::SQ_W'(mag_s1) * spes_pkg::SQ_W'(mag_s1);
		push_item.div  = div_s1;
		push_idx       = idx_s1;
	end

endmodule

// ===== design/spes_back.sv =====
// Back part: bit-serial divider, running maximum and the result register.
module spes_back #(
	parameter int IDX_W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 entry_valid,
	input  spes_pkg::spes_item_t entry,
	input  logic [IDX_W-1:0]     entry_idx,
	output logic                 pop,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [63:0]          m_axis_tdata,
	output logic                 m_axis_tuser
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_UPD  = 3'b100
	} back_state_t;

	localparam int DW = spes_pkg::DATA_W;
	localparam int PW = spes_pkg::PRICE_W;

	back_state_t                   state_q;
	logic                          cand_q;
	logic                          last_q;
	logic [IDX_W-1:0]              idx_q;
	logic [DW-1:0]                 dvs_q;
	logic [DW-1:0]                 rem_q;
	logic [PW-1:0]                 quo_q;
	logic [spes_pkg::CNT_W-1:0]    cnt_q;
	logic [PW-1:0]                 best_q;
	logic [IDX_W-1:0]              best_idx_q;
	logic                          any_q;
	logic                          out_valid_q;
	logic [spes_pkg::PORT_IDX_W-1:0] out_idx_q;
	logic                          out_found_q;
	logic [PW-1:0]                 out_price_q;

	logic [DW-1:0]                 head;
	logic                          sat;
	logic [DW:0]                   rem_sh;
	logic                          ge;
	logic                          upd_take;
	logic                          out_free;
	logic                          out_load;
	logic [PW-1:0]                 best_n;
	logic [IDX_W-1:0]              best_idx_n;
	logic [spes_pkg::PORT_IDX_W-1:0] idx_ext;

	assign head     = DW'(entry.sq[spes_pkg::SQ_W-1:PW]);
	assign sat      = (entry.div == '0) || (head >= entry.div);
	assign rem_sh   = {rem_q, quo_q[PW-1]};
	assign ge       = rem_sh >= {1'b0, dvs_q};
	assign pop      = (state_q == ST_IDLE) && entry_valid;
	assign out_free = !out_valid_q || m_axis_tready;
	assign out_load = (state_q == ST_UPD) && last_q && out_free;
	assign upd_take = cand_q && (!any_q || (quo_q > best_q));
	assign best_n     = upd_take ? quo_q : best_q;
	assign best_idx_n = upd_take ? idx_q : best_idx_q;

	always_comb begin
		idx_ext = '0;
		idx_ext[IDX_W-1:0] = best_idx_n;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_price_q, out_idx_q};
	assign m_axis_tuser  = out_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			any_q       <= 1'b0;
			best_q      <= '0;
			best_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (entry_valid) begin
						state_q <= (entry.cand && !sat) ? ST_DIV : ST_UPD;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (!last_q) begin
						best_q     <= best_n;
						best_idx_q <= best_idx_n;
						any_q      <= any_q || cand_q;
						state_q    <= ST_IDLE;
					end else if (out_free) begin
						best_q      <= '0;
						best_idx_q  <= '0;
						any_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (entry_valid) begin
					cand_q <= entry.cand;
					last_q <= entry.last;
					idx_q  <= entry_idx;
					dvs_q  <= entry.div;
					rem_q  <= head;
					quo_q  <= sat ? spes_pkg::PRICE_MAX : entry.sq[PW-1:0];
					cnt_q  <= spes_pkg::CNT_W'(PW - 1);
				end
			end
			ST_DIV: begin
				rem_q <= ge ? DW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DW-1:0];
				quo_q <= {quo_q[PW-2:0], ge};
				cnt_q <= cnt_q - spes_pkg::CNT_W'(1);
			end
			ST_UPD: begin
				if (last_q && out_free) begin
					out_found_q <= any_q || cand_q;
					out_idx_q   <= (any_q || cand_q) ? idx_ext : '0;
					out_price_q <= (any_q || cand_q) ? best_n : '0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== design/steepest_edge_price_select_top.sv =====
// Top level of the steepest-edge price selector: front, queue and back.
//
// Items are taken at up to one per cycle until the queue between front and back
// fills. The back unit handles one queued item at a time: an item that is not a
// candidate, or whose price saturates, goes from idle straight to update; other
// candidates first pass the divide state, where the one-bit-per-cycle divider
// forms the 48-bit price. An item reaches the back unit via the front register
// and then the queue. A scan's result shows on the master side in the cycle after
// its last item finishes, held in an output register that does not block the
// back unit until the next scan's last item is ready. No reset sweep is needed.
module steepest_edge_price_select_top #(
	parameter int INDEX_BITS  = 16,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // violation, weight, var_index
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // best_index, best_price
	output logic        m_axis_tuser   // found
);

	localparam int IDX_W  = (INDEX_BITS < spes_pkg::PORT_IDX_W) ? INDEX_BITS
	                                                            : spes_pkg::PORT_IDX_W;
	localparam int ITEM_W = $bits(spes_pkg::spes_item_t);
	localparam int Q_W    = ITEM_W + IDX_W;

	logic                 push;
	logic                 queue_full;
	logic                 queue_valid;
	logic                 pop;
	spes_pkg::spes_item_t push_item;
	spes_pkg::spes_item_t pop_item;
	logic [IDX_W-1:0]     push_idx;
	logic [IDX_W-1:0]     pop_idx;
	logic [Q_W-1:0]       q_in;
	logic [Q_W-1:0]       q_out;

	assign q_in     = {push_idx, push_item};
	assign pop_item = spes_pkg::spes_item_t'(q_out[ITEM_W-1:0]);
	assign pop_idx  = q_out[Q_W-1:ITEM_W];

	spes_front #(
		.IDX_W(IDX_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.push         (push),
		.push_item    (push_item),
		.push_idx     (push_idx),
		.queue_full   (queue_full)
	);

	spes_fifo #(
		.WIDTH(Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(q_in),
		.full     (queue_full),
		.pop      (pop),
		.pop_data (q_out),
		.not_empty(queue_valid)
	);

	spes_back #(
		.IDX_W(IDX_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry_valid  (queue_valid),
		.entry        (pop_item),
		.entry_idx    (pop_idx),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

// ===== design/spes_checker.sv =====
// Port-level checks for the steepest-edge price selector and their binding.
module spes_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("Stalled result item changed or was dropped.");

	a_empty_scan: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 64'd0)
		else $error("Scan without a candidate reported a nonzero index or price.");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid && s_axis_tready)
		else $error("Block not quiet and ready during reset.");

	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !$isunknown({m_axis_tdata, m_axis_tuser}))
		else $error("Result item carries unknown bits.");

endmodule

bind steepest_edge_price_select_top spes_checker u_spes_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
